>>> src/dpc_pkg.sv
// Shared constants, types and commands for the depth deprojection block.
package dpc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Numerator is {offset magnitude * depth, 16 zero bits} plus half the divisor.
  localparam int MAG_W      = 25;
  localparam int PROD_W     = MAG_W + 16;
  localparam int NUM_W      = PROD_W + 17;
  localparam int DEN_W      = 34;
  localparam int DIV_STEPS  = NUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_UNIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

  localparam logic [1:0] UNIT_CM = 2'd1;
  localparam logic [1:0] UNIT_M  = 2'd2;

  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2
  } sel_t;

  typedef struct packed {
    logic accept;
    logic setup_mul;
    logic setup_num;
    logic div_step;
    logic store;
    logic load_out;
    sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> src/dpc_ifaces.sv
// Valid/ready channel interfaces for depth samples and points.
interface dpc_depth_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_sample;
  modport source (output valid, output depth_sample, input ready);
  modport sink (input valid, input depth_sample, output ready);
endinterface

interface dpc_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic        [31:0] point_z;
  logic               frame_end;
  modport source (output valid, output point_x, output point_y, output point_z,
                  output frame_end, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input frame_end, output ready);
endinterface

>>> src/dpc_ctrl.sv
// Sequencer for the deprojection datapath: setup, long division, output.
module dpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dpc_pkg::dp_status_t status,
  output dpc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SETUP_MUL = 6'b000010,
    ST_SETUP_NUM = 6'b000100,
    ST_DIVIDE    = 6'b001000,
    ST_STORE     = 6'b010000,
    ST_DONE      = 6'b100000
  } state_t;

  state_t                     state, state_next;
  dpc_pkg::sel_t              sel, sel_next;
  logic [dpc_pkg::STEP_W-1:0] step, step_next;

  always_comb begin
    state_next = state;
    sel_next   = sel;
    step_next  = step;
    cmd        = '0;
    cmd.sel    = sel;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          sel_next   = dpc_pkg::SEL_X;
          state_next = ST_SETUP_MUL;
        end
      end
      ST_SETUP_MUL: begin
        cmd.setup_mul = 1'b1;
        state_next    = ST_SETUP_NUM;
      end
      ST_SETUP_NUM: begin
        cmd.setup_num = 1'b1;
        step_next     = '0;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == dpc_pkg::STEP_W'(dpc_pkg::DIV_STEPS - 1)) state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        case (sel)
          dpc_pkg::SEL_X: begin
            sel_next   = dpc_pkg::SEL_Y;
            state_next = ST_SETUP_MUL;
          end
          dpc_pkg::SEL_Y: begin
            sel_next   = dpc_pkg::SEL_Z;
            state_next = ST_SETUP_MUL;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_DONE: begin
        // hold the finished point until the output register is free
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= dpc_pkg::SEL_X;
      step  <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      step  <= step_next;
    end
  end

endmodule

>>> src/dpc_datapath.sv
// Config registers, pixel counters, multipliers, shared divider, output register.
module dpc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [15:0]                         depth_sample,
  input  dpc_pkg::dp_cmd_t                    cmd,
  output dpc_pkg::dp_status_t                 status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [31:0]                  point_x,
  output logic signed [31:0]                  point_y,
  output logic        [31:0]                  point_z,
  output logic                                frame_end
);

  logic [23:0]                  focal_x, focal_y;
  logic signed [23:0]           center_x, center_y;
  logic [1:0]                   depth_unit;
  logic [dpc_pkg::SIZE_W-1:0]   frame_width, frame_height;

  logic [dpc_pkg::COL_W-1:0]    col;
  logic [dpc_pkg::ROW_W-1:0]    row;
  logic [dpc_pkg::SIZE_W-1:0]   w_eff, h_eff;
  logic                         row_end, last;

  logic [15:0]                  depth_r;
  logic [dpc_pkg::MAG_W-1:0]    mag_x, mag_y;
  logic                         neg_x, neg_y, last_r;
  logic signed [25:0]           dx, dy;

  logic [9:0]                   scale;
  logic [dpc_pkg::MAG_W-1:0]    mul_a;
  logic [23:0]                  mul_f;
  logic [dpc_pkg::PROD_W-1:0]   prod;
  logic [dpc_pkg::DEN_W-1:0]    den;
  logic [dpc_pkg::NUM_W-1:0]    num;
  logic [dpc_pkg::DEN_W-1:0]    rem;
  logic [dpc_pkg::DEN_W:0]      rem_sh;
  logic                         ge;
  logic [31:0]                  quo;
  logic                         ovf, sat, neg_sel;
  logic [31:0]                  res_x, res_y, res_z, res_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= 24'd256;
      focal_y      <= 24'd256;
      center_x     <= '0;
      center_y     <= '0;
      depth_unit   <= '0;
      frame_width  <= dpc_pkg::SIZE_W'(640);
      frame_height <= dpc_pkg::SIZE_W'(400);
    end else if (cfg_write) begin
      case (cfg_index)
        dpc_pkg::REG_FOCAL_X:      focal_x      <= cfg_data;
        dpc_pkg::REG_FOCAL_Y:      focal_y      <= cfg_data;
        dpc_pkg::REG_CENTER_X:     center_x     <= $signed(cfg_data);
        dpc_pkg::REG_CENTER_Y:     center_y     <= $signed(cfg_data);
        dpc_pkg::REG_DEPTH_UNIT:   depth_unit   <= cfg_data[1:0];
        dpc_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[dpc_pkg::SIZE_W-1:0];
        dpc_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[dpc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to [1, max].
  always_comb begin
    if (frame_width == '0) w_eff = dpc_pkg::SIZE_W'(1);
    else if (frame_width > dpc_pkg::SIZE_W'(dpc_pkg::MAX_WIDTH))
      w_eff = dpc_pkg::SIZE_W'(dpc_pkg::MAX_WIDTH);
    else w_eff = frame_width;
    if (frame_height == '0) h_eff = dpc_pkg::SIZE_W'(1);
    else if (frame_height > dpc_pkg::SIZE_W'(dpc_pkg::MAX_HEIGHT))
      h_eff = dpc_pkg::SIZE_W'(dpc_pkg::MAX_HEIGHT);
    else h_eff = frame_height;
    row_end = dpc_pkg::SIZE_W'(col) >= w_eff - 1'b1;
    last    = row_end && (dpc_pkg::SIZE_W'(row) >= h_eff - 1'b1);
    dx = $signed({6'b0, col, 8'b0}) - 26'(center_x);
    dy = $signed({6'b0, row, 8'b0}) - 26'(center_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.accept) begin
      if (row_end) begin
        col <= '0;
        row <= last ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      depth_r <= depth_sample;
      neg_x   <= dx[25];
      neg_y   <= dy[25];
      mag_x   <= dx[25] ? dpc_pkg::MAG_W'(-dx) : dpc_pkg::MAG_W'(dx);
      mag_y   <= dy[25] ? dpc_pkg::MAG_W'(-dy) : dpc_pkg::MAG_W'(dy);
      last_r  <= last;
    end
  end

  always_comb begin
    case (depth_unit)
      dpc_pkg::UNIT_CM: scale = 10'd10;
      dpc_pkg::UNIT_M:  scale = 10'd1000;
      default:          scale = 10'd1;
    endcase
    case (cmd.sel)
      dpc_pkg::SEL_X: begin
        mul_a   = mag_x;
        mul_f   = (focal_x == '0) ? 24'd1 : focal_x;
        neg_sel = neg_x;
      end
      dpc_pkg::SEL_Y: begin
        mul_a   = mag_y;
        mul_f   = (focal_y == '0) ? 24'd1 : focal_y;
        neg_sel = neg_y;
      end
      default: begin
        mul_a   = dpc_pkg::MAG_W'(1);
        mul_f   = 24'd1;
        neg_sel = 1'b0;
      end
    endcase
    rem_sh = {rem, num[dpc_pkg::NUM_W-1]};
    ge     = rem_sh >= {1'b0, den};
    sat    = ovf | quo[31];
    if (cmd.sel == dpc_pkg::SEL_Z) res_val = quo;
    else if (neg_sel) res_val = sat ? 32'h8000_0000 : 32'(-quo);
    else res_val = sat ? 32'h7FFF_FFFF : quo;
  end

  // Restoring division, one quotient bit a cycle; bits above 31 only mark overflow.
  always_ff @(posedge clk) begin
    if (cmd.setup_mul) begin
      prod <= dpc_pkg::PROD_W'(mul_a) * dpc_pkg::PROD_W'(depth_r);
      den  <= dpc_pkg::DEN_W'(scale) * dpc_pkg::DEN_W'(mul_f);
    end
    if (cmd.setup_num) begin
      num <= {1'b0, prod, 16'b0} + dpc_pkg::NUM_W'(den >> 1);
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (cmd.div_step) begin
      num <= num << 1;
      rem <= ge ? dpc_pkg::DEN_W'(rem_sh - {1'b0, den}) : rem_sh[dpc_pkg::DEN_W-1:0];
      quo <= {quo[30:0], ge};
      ovf <= ovf | quo[31];
    end
    if (cmd.store) begin
      case (cmd.sel)
        dpc_pkg::SEL_X: res_x <= res_val;
        dpc_pkg::SEL_Y: res_y <= res_val;
        default:        res_z <= res_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      point_x   <= $signed(res_x);
      point_y   <= $signed(res_y);
      point_z   <= res_z;
      frame_end <= last_r;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

>>> src/depth_to_point_cloud.sv
// Top level of the pinhole depth deprojection block.
// Usage:
//   depth_in carries one 16-bit depth sample per pixel in raster order; the
//   block counts column and row itself and wraps at the end of each frame.
//   point_out carries one point per sample: x, y (signed Q16.16, saturated),
//   z (unsigned Q16.16) and frame_end on the frame's last pixel.
//   The config port writes one register per cycle when cfg_write is high;
//   write it only while no sample is in flight.
// Schedule:
//   Each sample runs three 58-step long divisions (x, y, z) through one shared
//   restoring divider, each preceded by the multiply and numerator setup states
//   and followed by a store state; then the point is loaded into the output
//   register, and no new sample is taken before that load. The divider loop
//   does most of the work.
// Reset (rst, synchronous): registers return to defaults, counters to the
//   first pixel, the output register empties.
// Stall: a finished point waits in the output register; the next sample is
//   still taken and processed, and its point is held until the register frees.
module depth_to_point_cloud (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data,
  dpc_depth_if.sink                      depth_in,
  dpc_point_if.source                    point_out
);

  dpc_pkg::dp_cmd_t    cmd;
  dpc_pkg::dp_status_t status;

  dpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (depth_in.valid),
    .in_ready (depth_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dpc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .depth_sample (depth_in.depth_sample),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (point_out.ready),
    .out_valid    (point_out.valid),
    .point_x      (point_out.point_x),
    .point_y      (point_out.point_y),
    .point_z      (point_out.point_z),
    .frame_end    (point_out.frame_end)
  );

endmodule

>>> src/dpc_checker.sv
// Port-level assertions for the deprojection block, bound to the top level.
module dpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] point_z
);

  // one sample at a time: ready drops right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready after transfer");

  // no point appears in the cycle after a transfer while the output is empty
  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("point appeared too early");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_z))
    else $error("stalled point dropped or changed");

endmodule

bind depth_to_point_cloud dpc_checker u_dpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (depth_in.valid),
  .in_ready  (depth_in.ready),
  .out_valid (point_out.valid),
  .out_ready (point_out.ready),
  .point_z   (point_out.point_z)
);

>>> verif/testbench.sv
// Testbench for the depth deprojection block: directed and random raster stimulus against a predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD    = 3000;
  localparam int STALL_LIMIT  = 20000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] z;
    logic               last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           cfg_write;
  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data;

  dpc_depth_if din();
  dpc_point_if pout();

  depth_to_point_cloud uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .depth_in(din), .point_out(pout)
  );

  // Predictor copy of configuration and pixel position
  logic [23:0] fx_q8, fy_q8;
  logic signed [23:0] cx_q8, cy_q8;
  logic [1:0]  unit_sel;
  logic [12:0] width_reg, height_reg;
  logic [11:0] col_pos, row_pos;

  logic [15:0] depth_pending[$];
  point_t      points_due[$];
  int          errors = 0;
  bit          send_burst = 0;
  bit          recv_burst = 0;
  bit          long_hold_go = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] deproject(longint offset_q8, logic [15:0] depth,
                                            longint unsigned scale, logic [23:0] focal);
    longint unsigned mag, den, num, q;
    bit neg;
    neg = offset_q8 < 0;
    mag = neg ? -offset_q8 : offset_q8;
    den = scale * ((focal == 0) ? 64'd1 : 64'(focal));
    num = mag * 64'(depth) * 64'd65536;
    q = (num + den / 2) / den;
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
  endfunction

  function automatic longint unsigned size_used(logic [12:0] v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // Compute the point for one accepted sample and advance the raster position
  task automatic predict_point(logic [15:0] depth);
    longint unsigned scale, w, h;
    longint dx, dy;
    point_t p;
    bit row_end;
    scale = (unit_sel == dpc_pkg::UNIT_CM) ? 10 : (unit_sel == dpc_pkg::UNIT_M) ? 1000 : 1;
    w = size_used(width_reg, dpc_pkg::MAX_WIDTH);
    h = size_used(height_reg, dpc_pkg::MAX_HEIGHT);
    dx = longint'(col_pos) * 256 - longint'(cx_q8);
    dy = longint'(row_pos) * 256 - longint'(cy_q8);
    row_end = col_pos >= w - 1;
    p.x = deproject(dx, depth, scale, fx_q8);
    p.y = deproject(dy, depth, scale, fy_q8);
    p.z = 32'(((64'(depth) << 16) + scale / 2) / scale);
    p.last = row_end && (row_pos >= h - 1);
    points_due.insert(points_due.size(), p);
    if (row_end) begin
      col_pos = '0;
      row_pos = p.last ? 12'd0 : row_pos + 12'd1;
    end else begin
      col_pos++;
    end
  endtask

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  // Driver
  int send_wait = 0;
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      din.valid <= 1'b0;
    end else begin
      nv = din.valid;
      if (din.valid && din.ready) begin
        predict_point(din.depth_sample);
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (depth_pending.size() > 0) begin
          din.depth_sample <= depth_pending.pop_front();
          nv = 1'b1;
          send_wait = draw_gap(send_burst);
        end
      end
      din.valid <= nv;
    end
  end

  // Long receiver hold, counted apart from the monitor
  int  hold_left = 0;
  bit  hold_seen = 0;
  always @(posedge clk) begin
    if (long_hold_go != hold_seen) begin
      hold_seen <= long_hold_go;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor
  int  recv_wait = 0;
  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      pout.ready <= 1'b0;
    end else begin
      if (pout.valid && pout.ready) begin
        if (points_due.size() == 0) begin
          $error("point with no sample pending: x=%0d y=%0d z=%0d",
                 pout.point_x, pout.point_y, pout.point_z);
          errors++;
        end else begin
          e = points_due.pop_front();
          if (pout.point_x !== e.x) begin
            $error("point_x expected %0d got %0d", e.x, pout.point_x); errors++;
          end
          if (pout.point_y !== e.y) begin
            $error("point_y expected %0d got %0d", e.y, pout.point_y); errors++;
          end
          if (pout.point_z !== e.z) begin
            $error("point_z expected %0d got %0d", e.z, pout.point_z); errors++;
          end
          if (pout.frame_end !== e.last) begin
            $error("frame_end expected %0d got %0d", e.last, pout.frame_end); errors++;
          end
        end
        recv_wait = draw_gap(recv_burst);
      end
      if (hold_left > 0) begin
        pout.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        pout.ready <= 1'b0;
      end else begin
        pout.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  int quiet = 0;
  always @(posedge clk) begin
    if ((din.valid && din.ready) || (pout.valid && pout.ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic reg_write(logic [dpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [dpc_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      dpc_pkg::REG_FOCAL_X:      fx_q8 = val;
      dpc_pkg::REG_FOCAL_Y:      fy_q8 = val;
      dpc_pkg::REG_CENTER_X:     cx_q8 = val;
      dpc_pkg::REG_CENTER_Y:     cy_q8 = val;
      dpc_pkg::REG_DEPTH_UNIT:   unit_sel = val[1:0];
      dpc_pkg::REG_FRAME_WIDTH:  width_reg = val[12:0];
      dpc_pkg::REG_FRAME_HEIGHT: height_reg = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(logic [23:0] fx, logic [23:0] fy, logic [23:0] cx,
                           logic [23:0] cy, logic [1:0] unit, logic [12:0] w,
                           logic [12:0] h);
    @(posedge clk);
    reg_write(dpc_pkg::REG_FOCAL_X, fx);
    reg_write(dpc_pkg::REG_FOCAL_Y, fy);
    reg_write(dpc_pkg::REG_CENTER_X, cx);
    reg_write(dpc_pkg::REG_CENTER_Y, cy);
    reg_write(dpc_pkg::REG_DEPTH_UNIT, 24'(unit));
    reg_write(dpc_pkg::REG_FRAME_WIDTH, 24'(w));
    reg_write(dpc_pkg::REG_FRAME_HEIGHT, 24'(h));
    cfg_write <= 1'b0;
  endtask

  // Wait until every sample is sent and every point has arrived
  task automatic drain();
    while (depth_pending.size() > 0 || din.valid || points_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_focal();
    case ($urandom_range(0, 4))
      0: return 24'($urandom_range(0, 3));
      1: return 24'hFFFFFF;
      2: return 24'($urandom);
      default: return 24'($urandom_range(64, 2048));
    endcase
  endfunction

  function automatic logic [23:0] rand_center();
    case ($urandom_range(0, 4))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  function automatic logic [12:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'($urandom);
      default: return 13'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [15:0] rand_depth();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int phase_len;
    din.valid = 1'b0;
    din.depth_sample = '0;
    pout.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fx_q8 = 24'd256;  fy_q8 = 24'd256;
    cx_q8 = '0;       cy_q8 = '0;
    unit_sel = '0;
    width_reg = 13'd640;  height_reg = 13'd400;
    col_pos = '0;     row_pos = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Defaults from reset
    depth_pending = '{16'd0, 16'hFFFF, 16'd1, 16'h8000};
    drain();
    // Zero focal lengths, unit three, zero frame size, center extremes
    write_all(24'd0, 24'd0, 24'h800000, 24'h7FFFFF, 2'd3, 13'd0, 13'd0);
    depth_pending = '{16'hFFFF, 16'd12345, 16'd0};
    drain();
    // Oversized frame, meter unit, largest focal
    write_all(24'hFFFFFF, 24'd1, 24'h7FFFFF, 24'h800000, dpc_pkg::UNIT_M, 13'h1FFF,
              13'd4096);
    depth_pending = '{16'hFFFF, 16'd999, 16'd1};
    drain();
    // Small frame in centimeters, one frame end
    write_all(24'd256, 24'd512, 24'd256, 24'hFFFF00, dpc_pkg::UNIT_CM, 13'd3, 13'd2);
    depth_pending = '{16'd100, 16'd5, 16'd15, 16'd65530, 16'd7, 16'd4, 16'd1000};
    drain();
    // Narrow the frame and make it taller
    write_all(24'd300, 24'd300, 24'd0, 24'd0, 2'd0, 13'd2, 13'd8);
    depth_pending = '{16'd2000, 16'd3000, 16'd4000, 16'd5000};
    drain();

    for (int ph = 0; ph < 42; ph++) begin
      write_all(rand_focal(), rand_focal(), rand_center(), rand_center(),
                2'($urandom_range(0, 3)), rand_size(), rand_size());
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 48);
      for (int i = 0; i < phase_len; i++)
        depth_pending.insert(depth_pending.size(), rand_depth());
      if (ph == 10) begin
        send_burst = 1;
        long_hold_go = ~long_hold_go;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/dpc_pkg.sv
src/dpc_ifaces.sv
src/dpc_ctrl.sv
src/dpc_datapath.sv
src/depth_to_point_cloud.sv
src/dpc_checker.sv
verif/testbench.sv
